>>> src/tccw_pkg.sv
package tccw_pkg;

  localparam int DEF_WIDTH  = 80;
  localparam int DEF_HEIGHT = 25;

  localparam logic       OP_PUT  = 1'b0;
  localparam logic       OP_READ = 1'b1;

  localparam logic [7:0] CODE_NONE    = 8'd0;
  localparam logic [7:0] CODE_TAB     = 8'd9;
  localparam logic [7:0] CODE_NEWLINE = 8'd10;
  localparam logic [7:0] CHAR_SPACE   = 8'h20;
  localparam logic [7:0] BLANK_COLOR  = 8'h0F;

  localparam logic [15:0] BLANK_CELL = {BLANK_COLOR, CODE_NONE};
  localparam logic [15:0] SPACE_CELL = {BLANK_COLOR, CHAR_SPACE};

  localparam int TAB_SPACES = 4;
  localparam int SPW        = $clog2(TAB_SPACES + 1);

endpackage

>>> src/text_console_char_writer.sv
// Channel    | handshake             | payload
// -----------+-----------------------+--------------------------------------------------
// request    | req_valid / req_stall | operation, char_code, color, read_row, read_col
// response   | rsp_valid / rsp_stall | cursor_col, cursor_row, cursor_linear,
//            |                       | cell_char, cell_color, scrolled
//
// A read passes S_READ and S_RDATA, a zero code goes straight to S_DONE, a newline passes
// S_FIX alone, and a printed character, each space of a tab and each wrap take an S_FIX and
// S_PUT pair; a scroll writes one blank per column through the single memory write port. The
// screen store is a ring of rows; a scroll blanks the top row and moves the ring start. After
// reset every cell of the store is swept to blank with req_stall high. A new request is taken
// while the previous response waits under rsp_stall; its own response then holds until that one leaves.
module text_console_char_writer #(
  parameter int WIDTH  = tccw_pkg::DEF_WIDTH,
  parameter int HEIGHT = tccw_pkg::DEF_HEIGHT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  output logic        req_stall,
  input  logic        operation,
  input  logic [7:0]  char_code,
  input  logic [7:0]  color,
  input  logic [4:0]  read_row,
  input  logic [6:0]  read_col,
  output logic        rsp_valid,
  input  logic        rsp_stall,
  output logic [6:0]  cursor_col,
  output logic [4:0]  cursor_row,
  output logic [10:0] cursor_linear,
  output logic [7:0]  cell_char,
  output logic [7:0]  cell_color,
  output logic        scrolled
);
  import tccw_pkg::*;

  localparam int CW    = $clog2(WIDTH + 1);
  localparam int CAW   = $clog2(WIDTH);
  localparam int RW    = $clog2(HEIGHT + 2);
  localparam int PRW   = $clog2(HEIGHT);
  localparam int AW    = PRW + CAW;
  localparam int DEPTH = HEIGHT << CAW;

  typedef enum logic [7:0] {
    S_CLEAR = 8'b0000_0001,
    S_IDLE  = 8'b0000_0010,
    S_FIX   = 8'b0000_0100,
    S_PUT   = 8'b0000_1000,
    S_SCROLL = 8'b0001_0000,
    S_READ  = 8'b0010_0000,
    S_RDATA = 8'b0100_0000,
    S_DONE  = 8'b1000_0000
  } state_t;

  state_t           state, state_next;
  logic [RW-1:0]    row, row_next;
  logic [CW-1:0]    col, col_next;
  logic [PRW-1:0]   top, top_next;
  logic             scr, scr_next;
  logic [SPW-1:0]   spaces, spaces_next;
  logic [CAW-1:0]   scol, scol_next;
  logic [AW-1:0]    clr_addr, clr_next;

  logic [15:0]      wr_cell;
  logic [4:0]       rd_row_q;
  logic [6:0]       rd_col_q;
  logic             rd_ok;
  logic [15:0]      cell_q;
  logic [15:0]      rd_data;

  logic [15:0]      mem [DEPTH];
  logic             mem_we;
  logic [AW-1:0]    mem_waddr;
  logic [15:0]      mem_wdata;

  logic [RW-1:0]    row_sel;
  logic [CAW-1:0]   col_addr;
  logic [PRW:0]     phys_sum;
  logic [PRW-1:0]   phys_row;
  logic [AW-1:0]    cell_addr;

  logic             accept;
  logic             out_load;
  logic             wrap;
  logic [RW-1:0]    row_w;
  logic [CW-1:0]    col_w;
  logic [15:0]      col_ext;
  logic [15:0]      row_ext;
  logic [15:0]      lin;

  assign req_stall = (state != S_IDLE);
  assign accept    = req_valid && !req_stall;

  // shared row-ring address unit
  always_comb begin
    phys_sum = (PRW + 1)'(top) + (PRW + 1)'(row_sel);
    if (phys_sum >= (PRW + 1)'(HEIGHT)) begin
      phys_row = PRW'(phys_sum - (PRW + 1)'(HEIGHT));
    end else begin
      phys_row = PRW'(phys_sum);
    end
    cell_addr = {phys_row, col_addr};
  end

  assign wrap  = (col >= WIDTH);
  assign row_w = wrap ? RW'(row + RW'(1)) : row;
  assign col_w = wrap ? '0 : col;

  always_comb begin
    state_next  = state;
    row_next    = row;
    col_next    = col;
    top_next    = top;
    scr_next    = scr;
    spaces_next = spaces;
    scol_next   = scol;
    clr_next    = clr_addr;
    mem_we      = 1'b0;
    mem_waddr   = cell_addr;
    mem_wdata   = BLANK_CELL;
    row_sel     = row;
    col_addr    = col[CAW-1:0];
    out_load    = 1'b0;
    unique case (state)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_addr;
        clr_next  = AW'(clr_addr + AW'(1));
        if (clr_addr == AW'(DEPTH - 1)) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (req_valid) begin
          scr_next = 1'b0;
          if (operation == OP_READ) begin
            state_next = S_READ;
          end else if (char_code == CODE_NONE) begin
            state_next = S_DONE;
          end else begin
            state_next = S_FIX;
            if (char_code == CODE_NEWLINE) begin
              row_next    = RW'(row_w + RW'(1));
              col_next    = '0;
              spaces_next = '0;
            end else if (char_code == CODE_TAB) begin
              row_next    = row_w;
              col_next    = col_w;
              spaces_next = SPW'(TAB_SPACES);
            end else begin
              row_next    = row_w;
              col_next    = col_w;
              spaces_next = SPW'(1);
            end
          end
        end
      end
      S_FIX: begin
        if (row >= HEIGHT) begin
          scol_next  = '0;
          state_next = S_SCROLL;
        end else if (spaces == '0) begin
          state_next = S_DONE;
        end else begin
          state_next = S_PUT;
        end
      end
      S_PUT: begin
        if (wrap) begin
          col_next = '0;
          row_next = RW'(row + RW'(1));
        end else begin
          mem_we      = 1'b1;
          mem_wdata   = wr_cell;
          col_next    = CW'(col + CW'(1));
          spaces_next = SPW'(spaces - SPW'(1));
        end
        state_next = S_FIX;
      end
      S_SCROLL: begin
        mem_we    = 1'b1;
        mem_waddr = {top, scol};
        scol_next = CAW'(scol + CAW'(1));
        if (scol == CAW'(WIDTH - 1)) begin
          top_next   = (top == PRW'(HEIGHT - 1)) ? '0 : PRW'(top + PRW'(1));
          row_next   = RW'(row - RW'(1));
          scr_next   = 1'b1;
          state_next = S_FIX;
        end
      end
      S_READ: begin
        row_sel    = RW'(rd_row_q);
        col_addr   = CAW'(rd_col_q);
        state_next = S_RDATA;
      end
      S_RDATA: begin
        state_next = S_DONE;
      end
      S_DONE: begin
        if (!rsp_valid || !rsp_stall) begin
          out_load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      row      <= '0;
      col      <= '0;
      top      <= '0;
      scr      <= 1'b0;
      spaces   <= '0;
      scol     <= '0;
      clr_addr <= '0;
    end else begin
      state    <= state_next;
      row      <= row_next;
      col      <= col_next;
      top      <= top_next;
      scr      <= scr_next;
      spaces   <= spaces_next;
      scol     <= scol_next;
      clr_addr <= clr_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      wr_cell  <= (char_code == CODE_TAB) ? SPACE_CELL : {color, char_code};
      rd_row_q <= read_row;
      rd_col_q <= read_col;
      rd_ok    <= (read_row < HEIGHT) && (read_col < WIDTH);
      cell_q   <= '0;
    end else if (state == S_RDATA) begin
      cell_q <= rd_ok ? rd_data : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data <= mem[cell_addr];
  end

  assign col_ext = 16'(col);
  assign row_ext = 16'(row);
  assign lin     = 16'(row_ext * 16'(WIDTH)) + col_ext;

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (out_load) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      cursor_col    <= col_ext[6:0];
      cursor_row    <= row_ext[4:0];
      cursor_linear <= lin[10:0];
      cell_char     <= cell_q[7:0];
      cell_color    <= cell_q[15:8];
      scrolled      <= scr;
    end
  end

  a_idle_cursor: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> (row < HEIGHT) && (col <= WIDTH))
    else $error("cursor out of range while idle");

  a_scroll_row: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCROLL) |-> (row >= HEIGHT))
    else $error("scroll without cursor past last row");

  a_put_col: assert property (@(posedge clk) disable iff (rst)
    (state == S_PUT) && mem_we |-> (col < WIDTH) && (row < HEIGHT))
    else $error("character write outside the screen");

  a_top_range: assert property (@(posedge clk) disable iff (rst)
    top < HEIGHT)
    else $error("ring start out of range");

endmodule

>>> tb/tccw_checker.sv
module tccw_checker #(
  parameter int W = tccw_pkg::DEF_WIDTH,
  parameter int H = tccw_pkg::DEF_HEIGHT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  input  logic        req_stall,
  input  logic        operation,
  input  logic [7:0]  char_code,
  input  logic [7:0]  color,
  input  logic [4:0]  read_row,
  input  logic [6:0]  read_col,
  input  logic        rsp_valid,
  input  logic        rsp_stall,
  input  logic [6:0]  cursor_col,
  input  logic [4:0]  cursor_row,
  input  logic [10:0] cursor_linear,
  input  logic [7:0]  cell_char,
  input  logic [7:0]  cell_color,
  input  logic        scrolled,
  output int          fail_count,
  output int          pending,
  output int          result_count,
  output int          read_count,
  output int          scroll_count
);
  timeunit 1ns;
  timeprecision 1ps;
  import tccw_pkg::*;

  typedef struct packed {
    logic [6:0]  col;
    logic [4:0]  row;
    logic [10:0] linear;
    logic [7:0]  ch_code;
    logic [7:0]  attr;
    logic        scrolled;
  } console_rsp_t;

  logic [15:0]  screen [W*H];
  int           cur_row;
  int           cur_col;
  bit           did_scroll;
  console_rsp_t cursor_q [$];
  int           errs;
  int           nres;
  int           nreads;
  int           nscr;

  initial begin
    errs = 0;
    nres = 0;
    nreads = 0;
    nscr = 0;
  end

  task automatic roll_rows();
    int i;
    while (cur_row >= H) begin
      for (i = 0; i < W * (H - 1); i++) screen[i] = screen[i + W];
      for (i = W * (H - 1); i < W * H; i++) screen[i] = BLANK_CELL;
      if (cur_row > 0) cur_row--;
      did_scroll = 1'b1;
    end
  endtask

  task automatic wrap_if_full();
    if (cur_col >= W) begin
      cur_col = 0;
      cur_row++;
    end
  endtask

  task automatic put_glyph(input logic [7:0] code, input logic [7:0] attr);
    wrap_if_full();
    roll_rows();
    screen[cur_row * W + cur_col] = {attr, code};
    cur_col++;
  endtask

  task automatic console_step(input logic op, input logic [7:0] code, input logic [7:0] attr,
                              input logic [4:0] rr, input logic [6:0] rc,
                              output console_rsp_t r);
    int k;
    did_scroll = 1'b0;
    r = '0;
    if (op == OP_READ) begin
      if (int'(rr) < H && int'(rc) < W) begin
        r.ch_code = screen[int'(rr) * W + int'(rc)][7:0];
        r.attr    = screen[int'(rr) * W + int'(rc)][15:8];
      end
    end else if (code != CODE_NONE) begin
      wrap_if_full();
      if (code == CODE_NEWLINE) begin
        cur_col = 0;
        cur_row++;
        roll_rows();
      end else if (code == CODE_TAB) begin
        roll_rows();
        for (k = 0; k < TAB_SPACES; k++) put_glyph(CHAR_SPACE, BLANK_COLOR);
      end else begin
        put_glyph(code, attr);
      end
    end
    r.col      = 7'(cur_col);
    r.row      = 5'(cur_row);
    r.linear   = 11'(cur_row * W + cur_col);
    r.scrolled = did_scroll;
  endtask

  function automatic void field_check(string name, logic [10:0] want, logic [10:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errs++;
    end
  endfunction

  always @(posedge clk) begin
    console_rsp_t want;
    int i;
    if (rst) begin
      for (i = 0; i < W * H; i++) screen[i] = BLANK_CELL;
      cur_row = 0;
      cur_col = 0;
      cursor_q.delete();
    end else begin
      if (rsp_valid && !rsp_stall) begin
        if (cursor_q.size() == 0) begin
          $error("response transaction with no request outstanding");
          errs++;
        end else begin
          want = cursor_q.pop_front();
          field_check("cursor_col", 11'(want.col), 11'(cursor_col));
          field_check("cursor_row", 11'(want.row), 11'(cursor_row));
          field_check("cursor_linear", want.linear, cursor_linear);
          field_check("cell_char", 11'(want.ch_code), 11'(cell_char));
          field_check("cell_color", 11'(want.attr), 11'(cell_color));
          field_check("scrolled", 11'(want.scrolled), 11'(scrolled));
          nres++;
          if (want.scrolled) nscr++;
        end
      end
      if (req_valid && !req_stall) begin
        console_step(operation, char_code, color, read_row, read_col, want);
        cursor_q.push_back(want);
        if (operation == OP_READ) nreads++;
      end
    end
    fail_count   <= errs;
    pending      <= cursor_q.size();
    result_count <= nres;
    read_count   <= nreads;
    scroll_count <= nscr;
  end

endmodule

>>> tb/tb_text_console_char_writer.sv
module tb_text_console_char_writer;
  timeunit 1ns;
  timeprecision 1ps;
  import tccw_pkg::*;

  localparam int W           = DEF_WIDTH;
  localparam int H           = DEF_HEIGHT;
  localparam int TARGET      = 1750;
  localparam int LIMIT       = 3_000_000;
  localparam int HOLD_AT     = 300;
  localparam int HOLD_CYCLES = 400;
  localparam int CALM_LO     = 900;
  localparam int CALM_HI     = 1100;
  localparam int TAIL_CYCLES = 200;

  typedef enum int {
    SEQ_FILL,
    SEQ_NEWLINES,
    SEQ_TABS,
    SEQ_READS,
    SEQ_NOISE,
    SEQ_GLYPHS
  } seq_kind_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        req_valid;
  logic        req_stall;
  logic        operation;
  logic [7:0]  char_code;
  logic [7:0]  color;
  logic [4:0]  read_row;
  logic [6:0]  read_col;
  logic        rsp_valid;
  logic        rsp_stall;
  logic [6:0]  cursor_col;
  logic [4:0]  cursor_row;
  logic [10:0] cursor_linear;
  logic [7:0]  cell_char;
  logic [7:0]  cell_color;
  logic        scrolled;

  int          fail_count;
  int          pending;
  int          result_count;
  int          read_count;
  int          scroll_count;

  int          sent = 0;
  bit          calm = 1'b0;
  bit          hold_done = 1'b0;
  int          hold_left = 0;
  int          stall_left = 0;
  int          pass_left = 0;
  int unsigned cycles = 0;

  always #4 clk = ~clk;

  text_console_char_writer #(.WIDTH(W), .HEIGHT(H)) DUT (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_stall(req_stall),
    .operation(operation), .char_code(char_code), .color(color),
    .read_row(read_row), .read_col(read_col),
    .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
    .cursor_col(cursor_col), .cursor_row(cursor_row), .cursor_linear(cursor_linear),
    .cell_char(cell_char), .cell_color(cell_color), .scrolled(scrolled)
  );

  tccw_checker #(.W(W), .H(H)) u_checker (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_stall(req_stall),
    .operation(operation), .char_code(char_code), .color(color),
    .read_row(read_row), .read_col(read_col),
    .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
    .cursor_col(cursor_col), .cursor_row(cursor_row), .cursor_linear(cursor_linear),
    .cell_char(cell_char), .cell_color(cell_color), .scrolled(scrolled),
    .fail_count(fail_count), .pending(pending), .result_count(result_count),
    .read_count(read_count), .scroll_count(scroll_count)
  );

  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [7:0] rand_glyph();
    logic [7:0] c;
    do c = 8'($urandom_range(1, 255)); while (c == CODE_TAB || c == CODE_NEWLINE);
    return c;
  endfunction

  task automatic send_item(input logic op, input logic [7:0] code, input logic [7:0] attr,
                           input logic [4:0] rr, input logic [6:0] rc);
    int gap;
    req_valid <= 1'b1;
    operation <= op;
    char_code <= code;
    color     <= attr;
    read_row  <= rr;
    read_col  <= rc;
    do @(posedge clk); while (req_stall);
    if (op == OP_READ || code != CODE_NONE) sent++;
    gap = pick_gap();
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic put_char(input logic [7:0] code, input logic [7:0] attr);
    send_item(OP_PUT, code, attr, 5'($urandom), 7'($urandom));
  endtask

  task automatic read_cell(input logic [4:0] rr, input logic [6:0] rc);
    send_item(OP_READ, 8'($urandom), 8'($urandom), rr, rc);
  endtask

  // hold off the response channel once for a long stretch so the block backs up
  always @(posedge clk) begin
    if (rst) begin
      rsp_stall <= 1'b0;
    end else if (hold_left > 0) begin
      rsp_stall <= 1'b1;
      hold_left--;
    end else if (!hold_done && result_count >= HOLD_AT) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES - 1;
      rsp_stall <= 1'b1;
    end else if (stall_left > 0) begin
      rsp_stall <= 1'b1;
      stall_left--;
    end else if (pass_left > 0) begin
      rsp_stall <= 1'b0;
      pass_left--;
    end else begin
      rsp_stall <= 1'b0;
      stall_left = pick_gap();
      pass_left = calm ? 0 : $urandom_range(0, 12);
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    seq_kind_t kind;
    int n;
    int i;
    rst       = 1'b1;
    req_valid = 1'b0;
    operation = OP_PUT;
    char_code = CODE_NONE;
    color     = 8'h00;
    read_row  = 5'd0;
    read_col  = 7'd0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    read_cell(5'd0, 7'd0);
    read_cell(5'(H - 1), 7'(W - 1));
    read_cell(5'd31, 7'd127);
    read_cell(5'(H), 7'd0);
    read_cell(5'd0, 7'(W));
    put_char(CODE_NONE, 8'hFF);
    put_char(8'hFF, 8'hFF);
    put_char(8'h01, 8'h00);
    put_char(CODE_TAB, 8'hA5);
    put_char(CODE_NEWLINE, 8'h00);
    read_cell(5'd0, 7'd0);
    read_cell(5'd0, 7'd1);
    read_cell(5'd0, 7'd2);
    read_cell(5'd0, 7'd5);

    while (sent < TARGET) begin
      calm = (sent >= CALM_LO && sent < CALM_HI);
      case ($urandom_range(0, 9))
        0, 1, 2: kind = SEQ_FILL;
        3:       kind = SEQ_NEWLINES;
        4:       kind = SEQ_TABS;
        5, 6:    kind = SEQ_READS;
        7:       kind = SEQ_NOISE;
        default: kind = SEQ_GLYPHS;
      endcase
      case (kind)
        SEQ_FILL: begin
          put_char(CODE_NEWLINE, 8'($urandom));
          n = $urandom_range(0, 1) ? W : $urandom_range(W - 6, W);
          for (i = 0; i < n; i++) put_char(rand_glyph(), 8'($urandom));
          case ($urandom_range(0, 3))
            0: put_char(CODE_NEWLINE, 8'($urandom));
            1: put_char(CODE_TAB, 8'($urandom));
            2: put_char(rand_glyph(), 8'($urandom));
            default: read_cell(5'(H - 1), 7'($urandom_range(0, W - 1)));
          endcase
        end
        SEQ_NEWLINES: repeat ($urandom_range(1, 30)) put_char(CODE_NEWLINE, 8'($urandom));
        SEQ_TABS:     repeat ($urandom_range(1, 25)) put_char(CODE_TAB, 8'($urandom));
        SEQ_READS: begin
          repeat ($urandom_range(1, 8)) begin
            if ($urandom_range(0, 9) == 0) read_cell(5'($urandom), 7'($urandom));
            else read_cell(5'($urandom_range(0, H - 1)), 7'($urandom_range(0, W - 1)));
          end
        end
        SEQ_NOISE: begin
          repeat ($urandom_range(1, 6))
            send_item(1'($urandom), 8'($urandom), 8'($urandom), 5'($urandom), 7'($urandom));
        end
        default: repeat ($urandom_range(1, 20)) put_char(rand_glyph(), 8'($urandom));
      endcase
    end

    req_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Sent %0d requests: directed edge cases, line fills, tab and newline runs, noise.",
             sent);
    $display("Checked %0d responses, %0d cell reads, %0d that scrolled the screen.",
             result_count, read_count, scroll_count);
    if (fail_count == 0 && pending == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
